[rtl/core/rbiu_pkg.sv]
package rbiu_pkg;

   localparam int DEF_FRAC_BITS   = 16;
   localparam int DEF_VALUE_WIDTH = 32;

   localparam int MASS_W        = 32;
   localparam int INER_W        = 21;
   localparam int INER_ROW_W    = 3 * INER_W;
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = INER_ROW_W;
   localparam int REQ_TYPE_W    = 3;
   localparam int TINY_LIM_BITS = 15;

   // operation codes carried by req_type
   localparam logic [REQ_TYPE_W-1:0] REQ_IMPULSE     = 3'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_ANG_IMPULSE = 3'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_ADD_VEL     = 3'd2;
   localparam logic [REQ_TYPE_W-1:0] REQ_SET_VEL     = 3'd3;
   localparam logic [REQ_TYPE_W-1:0] REQ_ADD_ANG     = 3'd4;
   localparam logic [REQ_TYPE_W-1:0] REQ_SET_ANG     = 3'd5;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MASS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INER0 = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INER1 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INER2 = 2'd3;

   typedef enum logic [1:0] {
      XS_VEC_A,
      XS_VEC_B,
      XS_INER
   } xsel_type;

   typedef enum logic [1:0] {
      YS_INV_MASS,
      YS_VEC_A,
      YS_CROSS
   } ysel_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_LIN,
      OP_FIRST,
      OP_SUB,
      OP_ADD,
      OP_ANG
   } acc_op_type;

   typedef struct packed {
      logic                  mul_en;
      xsel_type              x_sel;
      logic [1:0]            x_idx;
      logic [1:0]            x_row;
      ysel_type              y_sel;
      logic [1:0]            y_idx;
      acc_op_type            op;
      logic [1:0]            dst;
      logic                  tiny_en;
      logic                  apply_en;
      logic [REQ_TYPE_W-1:0] apply_kind;
      logic                  out_load;
   } cmd_type;

   typedef struct packed {
      logic div_busy;
      logic out_free;
   } status_type;

endpackage

[rtl/core/rbiu_div.sv]
module rbiu_div import rbiu_pkg::*; #(
   parameter int FRAC_BITS = DEF_FRAC_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [MASS_W-1:0]    mass,
   output logic                 busy,
   output logic [2*FRAC_BITS:0] quot
);

   localparam int QW       = 2 * FRAC_BITS + 1;
   localparam int RW       = MASS_W + 1;
   localparam int CW       = $clog2(QW + 1);
   localparam int MMIN_RAW = ((1 << FRAC_BITS) + 5000) / 10000;
   localparam int MMIN     = (MMIN_RAW == 0) ? 1 : MMIN_RAW;

   logic [MASS_W-1:0] div_ff, div_in;
   logic [RW-1:0]     rem_ff, rem_in;
   logic [QW-1:0]     quot_ff, quot_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic [RW-1:0]     trial;
   logic              qbit;

   always_comb begin
      div_in  = div_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      // dividend is a single one at the top quotient bit
      trial   = {rem_ff[RW-2:0], (cnt_ff == CW'(QW))};
      qbit    = (trial >= {1'b0, div_ff});
      if (start) begin
         rem_in  = '0;
         quot_in = '0;
         cnt_in  = CW'(QW);
         div_in  = (mass < MASS_W'(MMIN)) ? MASS_W'(MMIN) : mass;
         busy_in = (mass != '0);
      end else if (busy_ff) begin
         rem_in  = qbit ? (trial - {1'b0, div_ff}) : trial;
         quot_in = {quot_ff[QW-2:0], qbit};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      div_ff <= div_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         quot_ff <= '0;
         busy_ff <= 1'b0;
      end else begin
         quot_ff <= quot_in;
         busy_ff <= busy_in;
      end
   end

   assign busy = busy_ff;
   assign quot = quot_ff;

endmodule

[rtl/core/rbiu_dp.sv]
module rbiu_dp import rbiu_pkg::*; #(
   parameter int FRAC_BITS   = DEF_FRAC_BITS,
   parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_wdata,
   input  logic                          req_accept,
   input  logic signed [VALUE_WIDTH-1:0] req_vec_a_x,
   input  logic signed [VALUE_WIDTH-1:0] req_vec_a_y,
   input  logic signed [VALUE_WIDTH-1:0] req_vec_a_z,
   input  logic signed [VALUE_WIDTH-1:0] req_vec_b_x,
   input  logic signed [VALUE_WIDTH-1:0] req_vec_b_y,
   input  logic signed [VALUE_WIDTH-1:0] req_vec_b_z,
   input  cmd_type                       cmd,
   output status_type                    status,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [VALUE_WIDTH-1:0] rsp_lin_vel_x,
   output logic signed [VALUE_WIDTH-1:0] rsp_lin_vel_y,
   output logic signed [VALUE_WIDTH-1:0] rsp_lin_vel_z,
   output logic signed [VALUE_WIDTH-1:0] rsp_ang_vel_x,
   output logic signed [VALUE_WIDTH-1:0] rsp_ang_vel_y,
   output logic signed [VALUE_WIDTH-1:0] rsp_ang_vel_z
);

   localparam int VW = VALUE_WIDTH;
   localparam int QW = 2 * FRAC_BITS + 1;
   localparam int MW = (VW > QW) ? VW : QW;
   localparam int PW = 2 * MW;
   localparam logic [63:0] TINY_THR =
      ((64'd1 << (2 * FRAC_BITS)) + 64'd999999) / 64'd1000000;
   localparam logic [VW-1:0] LIM_POS = {1'b0, {(VW-1){1'b1}}};
   localparam logic [VW-1:0] LIM_NEG = {1'b1, {(VW-1){1'b0}}};

   function automatic logic signed [VW-1:0] sat_v(input logic signed [VW+1:0] v);
      logic signed [VW-1:0] r;
      if (v[VW+1:VW-1] == 3'b000 || v[VW+1:VW-1] == 3'b111) begin
         r = v[VW-1:0];
      end else begin
         r = v[VW+1] ? LIM_NEG : LIM_POS;
      end
      return r;
   endfunction

   logic signed [VW-1:0]         vec_a_ff [3];
   logic signed [VW-1:0]         vec_b_ff [3];
   logic [INER_ROW_W-1:0]        iner_ff  [3];
   logic signed [VW-1:0]         lin_ff   [3];
   logic signed [VW-1:0]         ang_ff   [3];
   logic signed [VW-1:0]         cross_ff [3];
   logic signed [VW+1:0]         acc_ff;
   logic                         tiny_ff;
   logic [PW-1:0]                prod_ff;
   logic                         neg_ff;
   acc_op_type                   op_ff;
   logic [1:0]                   dst_ff;
   logic                         rsp_valid_ff;
   logic signed [VW-1:0]         out_lin_ff [3];
   logic signed [VW-1:0]         out_ang_ff [3];

   logic                         div_busy;
   logic [QW-1:0]                inv_mass;

   rbiu_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock (clock),
      .reset (reset),
      .start (csr_wr_en && csr_index == CSR_MASS),
      .mass  (csr_wdata[MASS_W-1:0]),
      .busy  (div_busy),
      .quot  (inv_mass)
   );

   // operand select and magnitude multiply
   logic signed [INER_W-1:0] iner_entry;
   logic signed [VW-1:0]     x_val, y_val;
   logic [VW-1:0]            x_abs, y_abs;
   logic                     x_neg, y_neg;
   logic [MW-1:0]            x_mag, y_mag;

   always_comb begin
      iner_entry = iner_ff[cmd.x_row][cmd.x_idx*INER_W +: INER_W];
      case (cmd.x_sel)
         XS_VEC_A: x_val = vec_a_ff[cmd.x_idx];
         XS_VEC_B: x_val = vec_b_ff[cmd.x_idx];
         XS_INER:  x_val = VW'(iner_entry);
         default:  x_val = '0;
      endcase
      case (cmd.y_sel)
         YS_VEC_A: y_val = vec_a_ff[cmd.y_idx];
         YS_CROSS: y_val = cross_ff[cmd.y_idx];
         default:  y_val = '0;
      endcase
      x_neg = x_val[VW-1];
      x_abs = x_neg ? (~x_val + 1'b1) : x_val;
      x_mag = MW'(x_abs);
      if (cmd.y_sel == YS_INV_MASS) begin
         y_neg = 1'b0;
         y_abs = '0;
         y_mag = MW'(inv_mass);
      end else begin
         y_neg = y_val[VW-1];
         y_abs = y_neg ? (~y_val + 1'b1) : y_val;
         y_mag = MW'(y_abs);
      end
   end

   // scale, truncate toward zero, saturate
   logic [PW-1:0]        q_full;
   logic [VW-1:0]        q_lim, q_mag;
   logic signed [VW+1:0] q_val, s_val;

   always_comb begin
      q_full = prod_ff >> FRAC_BITS;
      q_lim  = neg_ff ? LIM_NEG : LIM_POS;
      q_mag  = (q_full > PW'(q_lim)) ? q_lim : q_full[VW-1:0];
      q_val  = neg_ff ? -$signed({2'b00, q_mag}) : $signed({2'b00, q_mag});
      s_val  = acc_ff + q_val;
   end

   // small-vector test
   logic [VW-1:0]              a_abs [3];
   logic [2*TINY_LIM_BITS-1:0] a_sq  [3];
   logic [2*TINY_LIM_BITS+1:0] sq_sum;
   logic                       a_big;
   logic                       tiny_in;

   always_comb begin
      a_big = 1'b0;
      for (int k = 0; k < 3; k++) begin
         a_abs[k] = vec_a_ff[k][VW-1] ? (~vec_a_ff[k] + 1'b1) : vec_a_ff[k];
         a_big    = a_big | (|a_abs[k][VW-1:TINY_LIM_BITS]);
         a_sq[k]  = a_abs[k][TINY_LIM_BITS-1:0] * a_abs[k][TINY_LIM_BITS-1:0];
      end
      sq_sum  = (2*TINY_LIM_BITS+2)'(a_sq[0]) + (2*TINY_LIM_BITS+2)'(a_sq[1])
              + (2*TINY_LIM_BITS+2)'(a_sq[2]);
      tiny_in = !a_big && (64'(sq_sum) < TINY_THR);
   end

   logic signed [VW-1:0] lin_add [3];
   logic signed [VW-1:0] ang_add [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         lin_add[k] = sat_v((VW+2)'(lin_ff[k]) + (VW+2)'(vec_a_ff[k]));
         ang_add[k] = sat_v((VW+2)'(ang_ff[k]) + (VW+2)'(vec_a_ff[k]));
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         vec_a_ff[0] <= req_vec_a_x;
         vec_a_ff[1] <= req_vec_a_y;
         vec_a_ff[2] <= req_vec_a_z;
         vec_b_ff[0] <= req_vec_b_x;
         vec_b_ff[1] <= req_vec_b_y;
         vec_b_ff[2] <= req_vec_b_z;
      end
      prod_ff <= x_mag * y_mag;
      neg_ff  <= x_neg ^ y_neg;
      dst_ff  <= cmd.dst;
      if (cmd.tiny_en) begin
         tiny_ff <= tiny_in;
      end
      case (op_ff)
         OP_FIRST: acc_ff <= q_val;
         OP_ADD:   acc_ff <= s_val;
         OP_SUB:   cross_ff[dst_ff] <= sat_v(acc_ff - q_val);
         default:  ;
      endcase
      if (cmd.out_load) begin
         for (int k = 0; k < 3; k++) begin
            out_lin_ff[k] <= lin_ff[k];
            out_ang_ff[k] <= ang_ff[k];
         end
      end

      if (reset) begin
         op_ff        <= OP_NONE;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < 3; k++) begin
            iner_ff[k] <= '0;
            lin_ff[k]  <= '0;
            ang_ff[k]  <= '0;
         end
      end else begin
         op_ff <= cmd.mul_en ? cmd.op : OP_NONE;
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_INER0: iner_ff[0] <= csr_wdata;
               CSR_INER1: iner_ff[1] <= csr_wdata;
               CSR_INER2: iner_ff[2] <= csr_wdata;
               default:   ;
            endcase
         end
         if (op_ff == OP_LIN) begin
            lin_ff[dst_ff] <= sat_v((VW+2)'(lin_ff[dst_ff]) + q_val);
         end else if (op_ff == OP_ANG) begin
            ang_ff[dst_ff] <= sat_v((VW+2)'(ang_ff[dst_ff]) + (VW+2)'(sat_v(s_val)));
         end else if (cmd.apply_en) begin
            case (cmd.apply_kind)
               REQ_ADD_VEL: if (!tiny_ff) begin
                  lin_ff <= lin_add;
               end
               REQ_SET_VEL: for (int k = 0; k < 3; k++) begin
                  lin_ff[k] <= tiny_ff ? '0 : vec_a_ff[k];
               end
               REQ_ADD_ANG: if (!tiny_ff) begin
                  ang_ff <= ang_add;
               end
               REQ_SET_ANG: for (int k = 0; k < 3; k++) begin
                  ang_ff[k] <= tiny_ff ? '0 : vec_a_ff[k];
               end
               default: ;
            endcase
         end
      end
   end

   assign status.div_busy = div_busy;
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_lin_vel_x = out_lin_ff[0];
   assign rsp_lin_vel_y = out_lin_ff[1];
   assign rsp_lin_vel_z = out_lin_ff[2];
   assign rsp_ang_vel_x = out_ang_ff[0];
   assign rsp_ang_vel_y = out_ang_ff[1];
   assign rsp_ang_vel_z = out_ang_ff[2];

endmodule

[rtl/core/rbiu_ctrl.sv]
module rbiu_ctrl import rbiu_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [REQ_TYPE_W-1:0] req_type,
   input  status_type            status,
   output cmd_type               cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_WAIT,
      ST_RUN,
      ST_DRAIN,
      ST_TINY,
      ST_APPLY,
      ST_FINISH
   } state_type;

   localparam logic [4:0] STEP_ANG  = 5'd3;
   localparam logic [4:0] STEP_LAST = 5'd17;

   function automatic cmd_type mul_cmd(input xsel_type xs, input logic [1:0] xi,
                                       input logic [1:0] xr, input ysel_type ys,
                                       input logic [1:0] yi, input acc_op_type op,
                                       input logic [1:0] dst);
      cmd_type c;
      c        = '0;
      c.mul_en = 1'b1;
      c.x_sel  = xs;
      c.x_idx  = xi;
      c.x_row  = xr;
      c.y_sel  = ys;
      c.y_idx  = yi;
      c.op     = op;
      c.dst    = dst;
      return c;
   endfunction

   // product schedule: linear kick, cross product, then inertia rows
   function automatic cmd_type step_cmd(input logic [4:0] step);
      cmd_type c;
      case (step)
         5'd0:  c = mul_cmd(XS_VEC_A, 2'd0, 2'd0, YS_INV_MASS, 2'd0, OP_LIN, 2'd0);
         5'd1:  c = mul_cmd(XS_VEC_A, 2'd1, 2'd0, YS_INV_MASS, 2'd0, OP_LIN, 2'd1);
         5'd2:  c = mul_cmd(XS_VEC_A, 2'd2, 2'd0, YS_INV_MASS, 2'd0, OP_LIN, 2'd2);
         5'd3:  c = mul_cmd(XS_VEC_B, 2'd1, 2'd0, YS_VEC_A, 2'd2, OP_FIRST, 2'd0);
         5'd4:  c = mul_cmd(XS_VEC_B, 2'd2, 2'd0, YS_VEC_A, 2'd1, OP_SUB, 2'd0);
         5'd5:  c = mul_cmd(XS_VEC_B, 2'd2, 2'd0, YS_VEC_A, 2'd0, OP_FIRST, 2'd1);
         5'd6:  c = mul_cmd(XS_VEC_B, 2'd0, 2'd0, YS_VEC_A, 2'd2, OP_SUB, 2'd1);
         5'd7:  c = mul_cmd(XS_VEC_B, 2'd0, 2'd0, YS_VEC_A, 2'd1, OP_FIRST, 2'd2);
         5'd8:  c = mul_cmd(XS_VEC_B, 2'd1, 2'd0, YS_VEC_A, 2'd0, OP_SUB, 2'd2);
         5'd9:  c = mul_cmd(XS_INER, 2'd0, 2'd0, YS_CROSS, 2'd0, OP_FIRST, 2'd0);
         5'd10: c = mul_cmd(XS_INER, 2'd1, 2'd0, YS_CROSS, 2'd1, OP_ADD, 2'd0);
         5'd11: c = mul_cmd(XS_INER, 2'd2, 2'd0, YS_CROSS, 2'd2, OP_ANG, 2'd0);
         5'd12: c = mul_cmd(XS_INER, 2'd0, 2'd1, YS_CROSS, 2'd0, OP_FIRST, 2'd1);
         5'd13: c = mul_cmd(XS_INER, 2'd1, 2'd1, YS_CROSS, 2'd1, OP_ADD, 2'd1);
         5'd14: c = mul_cmd(XS_INER, 2'd2, 2'd1, YS_CROSS, 2'd2, OP_ANG, 2'd1);
         5'd15: c = mul_cmd(XS_INER, 2'd0, 2'd2, YS_CROSS, 2'd0, OP_FIRST, 2'd2);
         5'd16: c = mul_cmd(XS_INER, 2'd1, 2'd2, YS_CROSS, 2'd1, OP_ADD, 2'd2);
         5'd17: c = mul_cmd(XS_INER, 2'd2, 2'd2, YS_CROSS, 2'd2, OP_ANG, 2'd2);
         default: c = '0;
      endcase
      return c;
   endfunction

   state_type             state_ff, state_in;
   logic [REQ_TYPE_W-1:0] kind_ff, kind_in;
   logic [4:0]            step_ff, step_in;
   cmd_type               cmd_ff, cmd_in;

   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      step_in  = step_ff;
      cmd_in   = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               kind_in = req_type;
               if (req_type == REQ_IMPULSE) begin
                  state_in = ST_DIV_WAIT;
                  step_in  = '0;
               end else if (req_type == REQ_ANG_IMPULSE) begin
                  state_in = ST_RUN;
                  step_in  = STEP_ANG;
               end else begin
                  state_in = ST_TINY;
               end
            end
         end
         ST_DIV_WAIT: begin
            if (!status.div_busy) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            cmd_in  = step_cmd(step_ff);
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_LAST) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: state_in = ST_FINISH;
         ST_TINY: begin
            cmd_in.tiny_en = 1'b1;
            state_in       = ST_APPLY;
         end
         ST_APPLY: begin
            cmd_in.apply_en   = 1'b1;
            cmd_in.apply_kind = kind_ff;
            state_in          = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd_in.out_load = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      step_ff <= step_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         cmd_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cmd_ff   <= cmd_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign cmd       = cmd_ff;

endmodule

[rtl/core/rigid_body_impulse_update_core.sv]
// channel  | handshake            | payload
// req      | req_valid/req_ready  | req_type, req_vec_a_x/y/z, req_vec_b_x/y/z
// rsp      | rsp_valid/rsp_ready  | rsp_lin_vel_x/y/z, rsp_ang_vel_x/y/z
// csr      | csr_wr_en            | csr_index, csr_wdata
//
// the 18 products of an impulse at point run one a cycle through the single
// shared multiplier; an angular impulse runs the same schedule without the
// linear kick, and velocity add/set and unused codes use no products.
// a mass write starts an inverse-mass divide; an impulse at point waits
// for it to finish.
// reset is synchronous and clears velocities, inertia rows and inverse mass.
// results sit in an output register; one item is in flight at a time.
module rigid_body_impulse_update_core import rbiu_pkg::*; #(
   parameter int FRAC_BITS   = DEF_FRAC_BITS,
   parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_wdata,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [REQ_TYPE_W-1:0]         req_type,
   input  logic signed [VALUE_WIDTH-1:0] req_vec_a_x,
   input  logic signed [VALUE_WIDTH-1:0] req_vec_a_y,
   input  logic signed [VALUE_WIDTH-1:0] req_vec_a_z,
   input  logic signed [VALUE_WIDTH-1:0] req_vec_b_x,
   input  logic signed [VALUE_WIDTH-1:0] req_vec_b_y,
   input  logic signed [VALUE_WIDTH-1:0] req_vec_b_z,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [VALUE_WIDTH-1:0] rsp_lin_vel_x,
   output logic signed [VALUE_WIDTH-1:0] rsp_lin_vel_y,
   output logic signed [VALUE_WIDTH-1:0] rsp_lin_vel_z,
   output logic signed [VALUE_WIDTH-1:0] rsp_ang_vel_x,
   output logic signed [VALUE_WIDTH-1:0] rsp_ang_vel_y,
   output logic signed [VALUE_WIDTH-1:0] rsp_ang_vel_z
);

   cmd_type    cmd;
   status_type status;

   rbiu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_type  (req_type),
      .status    (status),
      .cmd       (cmd)
   );

   rbiu_dp #(
      .FRAC_BITS   (FRAC_BITS),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_accept    (req_valid && req_ready),
      .req_vec_a_x   (req_vec_a_x),
      .req_vec_a_y   (req_vec_a_y),
      .req_vec_a_z   (req_vec_a_z),
      .req_vec_b_x   (req_vec_b_x),
      .req_vec_b_y   (req_vec_b_y),
      .req_vec_b_z   (req_vec_b_z),
      .cmd           (cmd),
      .status        (status),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_lin_vel_x (rsp_lin_vel_x),
      .rsp_lin_vel_y (rsp_lin_vel_y),
      .rsp_lin_vel_z (rsp_lin_vel_z),
      .rsp_ang_vel_x (rsp_ang_vel_x),
      .rsp_ang_vel_y (rsp_ang_vel_y),
      .rsp_ang_vel_z (rsp_ang_vel_z)
   );

endmodule

[rtl/core/rbiu_chk.sv]
module rbiu_chk (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready
);

   // held result must stay until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp_valid dropped before the item was taken");

   // one item in flight: no second accept right after one
   a_one_inflight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req_ready high right after an accept");

   // the previous result may still rise just after an accept; the new one
   // needs more work and must not rise right behind it
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> ##1 !$rose(rsp_valid))
      else $error("result appeared right after accept");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

endmodule

bind rigid_body_impulse_update_core rbiu_chk u_rbiu_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready)
);
